>>> hdl/zsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsa_pkg
// shared types and codes for the zonal statistics accumulator
// ----------------------------------------------------------------------------
package zsa_pkg;

    localparam int NUM_ZONES_DEF = 256;

    localparam logic [1:0] OP_ACC    = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] STAT_MEAN  = 3'd0;
    localparam logic [2:0] STAT_SUM   = 3'd1;
    localparam logic [2:0] STAT_MIN   = 3'd2;
    localparam logic [2:0] STAT_MAX   = 3'd3;
    localparam logic [2:0] STAT_COUNT = 3'd4;

    localparam logic [2:0] REG_STAT_SELECT = 3'd0;
    localparam logic [2:0] REG_VSKIP_EN    = 3'd1;
    localparam logic [2:0] REG_VSKIP_CODE  = 3'd2;
    localparam logic [2:0] REG_ZSKIP_EN    = 3'd3;
    localparam logic [2:0] REG_ZSKIP_CODE  = 3'd4;

    // classified command from the front end to the back end
    typedef struct packed {
        logic [1:0]  op;
        logic        in_table;
        logic [7:0]  zone;
        logic [31:0] sample;
    } zsa_cmd_t;

endpackage
`default_nettype wire

>>> hdl/zsa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsa_front
// classifies input items, drops nodata pixels, queues commands (2 deep)
// ----------------------------------------------------------------------------
module zsa_front #(
    parameter int NUM_ZONES = zsa_pkg::NUM_ZONES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_op,
    input  wire logic [7:0]       in_zone,
    input  wire logic [31:0]      in_sample,
    input  wire logic             vskip_en,
    input  wire logic [31:0]      vskip_code,
    input  wire logic             zskip_en,
    input  wire logic [7:0]       zskip_code,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output zsa_pkg::zsa_cmd_t     cmd
);
    import zsa_pkg::*;

    zsa_cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    logic       keep, push, pop;
    zsa_cmd_t   c;

    always_comb begin
        c.op       = in_op;
        c.zone     = in_zone;
        c.sample   = in_sample;
        c.in_table = ({24'd0, in_zone} < 32'(NUM_ZONES));
        keep = 1'b1;
        if (in_op == OP_ACC) begin
            if (zskip_en && in_zone == zskip_code) keep = 1'b0;
            if (vskip_en && in_sample == vskip_code) keep = 1'b0;
            if (!c.in_table) keep = 1'b0;
        end
        if (in_op == OP_UNUSED) keep = 1'b0;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push      = in_valid && in_ready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) q_reg[wr_reg] <= c;
    end
endmodule
`default_nettype wire

>>> hdl/zsa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsa_div
// restoring divider, 64 by 32 bit unsigned, one quotient bit per cycle
// ----------------------------------------------------------------------------
module zsa_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient
);
    logic [63:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic [6:0]  n_reg;
    logic [32:0] sh;

    assign busy     = (n_reg != 7'd0);
    assign quotient = q_reg;
    assign sh       = {r_reg[31:0], q_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= 7'd0;
        end else if (start) begin
            n_reg <= 7'd64;
        end else if (busy) begin
            n_reg <= n_reg - 7'd1;
        end
        if (start) begin
            q_reg <= dividend;
            r_reg <= 33'd0;
            d_reg <= divisor;
        end else if (busy) begin
            if (sh >= {1'b0, d_reg}) begin
                r_reg <= sh - {1'b0, d_reg};
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= sh;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/zsa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zsa_back
// zone table, read-modify-write per pixel, queries with result register
// ----------------------------------------------------------------------------
module zsa_back #(
    parameter int NUM_ZONES = zsa_pkg::NUM_ZONES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  zsa_pkg::zsa_cmd_t  cmd,
    input  wire logic [2:0]    stat_select,
    output logic               res_valid,
    input  wire logic          res_ready,
    output logic [7:0]         res_zone,
    output logic               res_present,
    output logic [63:0]        res_value
);
    import zsa_pkg::*;

    localparam int AW = (NUM_ZONES > 256) ? 8 : $clog2(NUM_ZONES);
    localparam int TD = (NUM_ZONES > 256) ? 256 : NUM_ZONES;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_QRD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  st_reg;
    logic [TD-1:0] valid_reg;
    logic [63:0] sum_mem [TD];
    logic [31:0] min_mem [TD];
    logic [31:0] max_mem [TD];
    logic [31:0] cnt_mem [TD];
    logic [63:0] sum_rd;
    logic [31:0] min_rd, max_rd, cnt_rd;
    zsa_cmd_t    c_reg;
    logic        hit_reg, neg_reg;
    logic [AW-1:0] a;
    logic [64:0] sum_add;
    logic [63:0] sum_new, mag, qneg;
    logic        div_start, div_busy;
    logic [63:0] div_q;

    assign a = c_reg.zone[AW-1:0];
    assign cmd_ready = (st_reg == S_IDLE) && !res_valid;

    always_ff @(posedge aclk) begin
        sum_rd <= sum_mem[a];
        min_rd <= min_mem[a];
        max_rd <= max_mem[a];
        cnt_rd <= cnt_mem[a];
        if (st_reg == S_UPD) begin
            sum_mem[a] <= hit_reg ? sum_new : {{32{c_reg.sample[31]}}, c_reg.sample};
            min_mem[a] <= (hit_reg && $signed(min_rd) <= $signed(c_reg.sample))
                          ? min_rd : c_reg.sample;
            max_mem[a] <= (hit_reg && $signed(max_rd) >= $signed(c_reg.sample))
                          ? max_rd : c_reg.sample;
            cnt_mem[a] <= !hit_reg ? 32'd1 : (cnt_rd == 32'hFFFF_FFFF) ? cnt_rd
                          : cnt_rd + 32'd1;
        end
    end

    always_comb begin
        sum_add = {sum_rd[63], sum_rd} + {{33{c_reg.sample[31]}}, c_reg.sample};
        if (sum_add[64] != sum_add[63])
            sum_new = sum_add[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else
            sum_new = sum_add[63:0];
        mag  = sum_rd[63] ? (64'd0 - sum_rd) : sum_rd;
        qneg = 64'd0 - div_q;
    end

    assign div_start = (st_reg == S_QRD) && hit_reg && stat_select == STAT_MEAN;

    zsa_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(mag),
        .divisor(cnt_rd), .busy(div_busy), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            valid_reg <= '0;
            res_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) res_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (cmd_valid && cmd_ready) begin
                    c_reg   <= cmd;
                    hit_reg <= cmd.in_table && valid_reg[cmd.zone[AW-1:0]];
                    priority case (cmd.op)
                        OP_ACC:   st_reg <= S_RD;
                        OP_QUERY: st_reg <= S_RD;
                        default:  valid_reg <= '0;
                    endcase
                end
                // table read data is registered, valid in the cycle after the address
                S_RD: st_reg <= (c_reg.op == OP_QUERY) ? S_QRD : S_UPD;
                S_UPD: begin
                    valid_reg[a] <= 1'b1;
                    st_reg <= S_IDLE;
                end
                S_QRD: begin
                    neg_reg <= sum_rd[63];
                    res_zone <= c_reg.zone;
                    res_present <= hit_reg;
                    if (!hit_reg) res_value <= 64'd0;
                    else begin
                        unique case (stat_select)
                            STAT_SUM:   res_value <= sum_rd;
                            STAT_MIN:   res_value <= {{32{min_rd[31]}}, min_rd};
                            STAT_MAX:   res_value <= {{32{max_rd[31]}}, max_rd};
                            STAT_COUNT: res_value <= {32'd0, cnt_rd};
                            default:    res_value <= 64'd0;
                        endcase
                    end
                    st_reg <= div_start ? S_DIV : S_OUT;
                end
                S_DIV: if (!div_busy) begin
                    res_value <= neg_reg ? qneg : div_q;
                    st_reg <= S_OUT;
                end
                S_OUT: begin
                    res_valid <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/zonal_statistics_accumulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zonal_statistics_accumulator_top
// per-zone sum, min, max, count and mean over a stream of q16.16 pixels
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)              | tuser
// s_      | in  | zone[7:0], sample[39:8]                | op[1:0]
// m_      | out | zone_out[7:0], present[8], stat[72:9]  | none
// apb     | in  | five registers at byte address 4*i     |
//
// accumulate: the table sequencer goes through read, update and back to idle
// query: read, wait for read data, load result, hand off, transfer,
// mean adds a pass through the bit-serial divider
// clear and skipped pixels need no table pass; a 2-entry queue decouples the input
// reset clears the valid bits at once, no clearing pass
// the result register holds a transfer until m_tready; the queue keeps filling
// ----------------------------------------------------------------------------
module zonal_statistics_accumulator_top #(
    parameter int NUM_ZONES = zsa_pkg::NUM_ZONES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // zone[7:0], sample[39:8]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // zone_out[7:0], present[8], stat_value[72:9]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import zsa_pkg::*;

    logic [2:0]  stat_sel_reg;
    logic        vskip_en_reg, zskip_en_reg;
    logic [31:0] vskip_code_reg;
    logic [7:0]  zskip_code_reg;
    logic        wr;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_sel_reg   <= 3'd0;
            vskip_en_reg   <= 1'b0;
            vskip_code_reg <= 32'd0;
            zskip_en_reg   <= 1'b0;
            zskip_code_reg <= 8'd0;
        end else if (wr && paddr[1:0] == 2'd0) begin
            unique case (ridx)
                REG_STAT_SELECT: stat_sel_reg   <= pwdata[2:0];
                REG_VSKIP_EN:    vskip_en_reg   <= pwdata[0];
                REG_VSKIP_CODE:  vskip_code_reg <= pwdata;
                REG_ZSKIP_EN:    zskip_en_reg   <= pwdata[0];
                REG_ZSKIP_CODE:  zskip_code_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_STAT_SELECT: prdata = {29'd0, stat_sel_reg};
            REG_VSKIP_EN:    prdata = {31'd0, vskip_en_reg};
            REG_VSKIP_CODE:  prdata = vskip_code_reg;
            REG_ZSKIP_EN:    prdata = {31'd0, zskip_en_reg};
            REG_ZSKIP_CODE:  prdata = {24'd0, zskip_code_reg};
            default:         prdata = 32'd0;
        endcase
    end

    logic     cmd_valid, cmd_ready;
    zsa_cmd_t cmd;
    logic [7:0]  r_zone;
    logic        r_present;
    logic [63:0] r_value;

    // front: classify and queue
    zsa_front #(.NUM_ZONES(NUM_ZONES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tuser), .in_zone(s_tdata[7:0]), .in_sample(s_tdata[39:8]),
        .vskip_en(vskip_en_reg), .vskip_code(vskip_code_reg),
        .zskip_en(zskip_en_reg), .zskip_code(zskip_code_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    // back: table and query
    zsa_back #(.NUM_ZONES(NUM_ZONES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .stat_select(stat_sel_reg),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_zone(r_zone), .res_present(r_present), .res_value(r_value)
    );

    assign m_tdata = {7'd0, r_value, r_present, r_zone};

`ifndef NO_ASSERTIONS
    // absent zone answers zero
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[72:9] == 64'd0))
        else $error("absent zone with nonzero value");
    // back end takes nothing while a result waits
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !cmd_ready)
        else $error("command taken while result pending");
    // count never reported as zero for a present zone
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8] && stat_sel_reg == STAT_COUNT)
        |-> (m_tdata[72:9] != 64'd0))
        else $error("present zone with zero count");
`endif
endmodule
`default_nettype wire

>>> tb/zonal_statistics_accumulator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zonal_statistics_accumulator_top_tb
// drives pixel, query, clear and unused-op transfers with random gaps on both sides,
// predicts each query answer from a local zone table and compares field by field
// ----------------------------------------------------------------------------
module zonal_statistics_accumulator_top_tb;
    import zsa_pkg::*;

    localparam int ZONES = 256;
    localparam int SETTLE_CYCLES = 120;   // exceeds the longest query, a mean

    // zone_out in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [63:0] stat_value;
        logic        present;
        logic [7:0]  zone_out;
    } zone_answer_t;

    // zone table model with its own register copy, plus the pending answers
    class zone_stats_board;
        bit                 valid [ZONES];
        longint             sum   [ZONES];
        int                 vmin  [ZONES];
        int                 vmax  [ZONES];
        int unsigned        count [ZONES];
        logic [2:0]         stat_sel;
        bit                 vskip_en, zskip_en;
        logic [31:0]        vskip_code;
        logic [7:0]         zskip_code;
        zone_answer_t       pending [$];
        int                 errors, answers;

        function void reset_state();
            foreach (valid[i]) valid[i] = 0;
            stat_sel = STAT_MEAN; vskip_en = 0; zskip_en = 0;
            vskip_code = '0; zskip_code = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_STAT_SELECT: stat_sel   = val[2:0];
                REG_VSKIP_EN:    vskip_en   = val[0];
                REG_VSKIP_CODE:  vskip_code = val;
                REG_ZSKIP_EN:    zskip_en   = val[0];
                REG_ZSKIP_CODE:  zskip_code = val[7:0];
                default: ;
            endcase
        endfunction

        function longint mean_trunc(longint s, int unsigned c);
            logic [63:0] mag, q;
            mag = (s < 0) ? -s : s;
            q = mag / {32'd0, c};
            return (s < 0) ? -q : q;
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] zone, logic [31:0] raw);
            int s;
            longint ns;
            zone_answer_t a;
            s = raw;
            if (op == OP_ACC) begin
                if (zskip_en && zone == zskip_code) return;
                if (vskip_en && raw == vskip_code) return;
                if (!valid[zone]) begin
                    valid[zone] = 1; sum[zone] = s; vmin[zone] = s; vmax[zone] = s;
                    count[zone] = 1;
                end else begin
                    ns = sum[zone] + s;
                    // signed overflow only when signs agree and the result flips
                    if (s > 0 && ns < sum[zone]) ns = 64'h7FFF_FFFF_FFFF_FFFF;
                    if (s < 0 && ns > sum[zone]) ns = 64'h8000_0000_0000_0000;
                    sum[zone] = ns;
                    if (s < vmin[zone]) vmin[zone] = s;
                    if (s > vmax[zone]) vmax[zone] = s;
                    if (count[zone] != 32'hFFFF_FFFF) count[zone]++;
                end
            end else if (op == OP_QUERY) begin
                a.zone_out = zone;
                a.present = valid[zone];
                a.stat_value = '0;
                if (valid[zone]) begin
                    case (stat_sel)
                        STAT_MEAN:  a.stat_value = mean_trunc(sum[zone], count[zone]);
                        STAT_SUM:   a.stat_value = sum[zone];
                        STAT_MIN:   a.stat_value = longint'(vmin[zone]);
                        STAT_MAX:   a.stat_value = longint'(vmax[zone]);
                        STAT_COUNT: a.stat_value = {32'd0, count[zone]};
                        default:    a.stat_value = '0;
                    endcase
                end
                pending.push_back(a);
            end else if (op == OP_CLEAR) begin
                foreach (valid[i]) valid[i] = 0;
            end
        endfunction

        function void check_answer(zone_answer_t got);
            zone_answer_t exp_a;
            answers++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected answer %h", $realtime, got);
                errors++;
                return;
            end
            exp_a = pending.pop_front();
            if (got.zone_out !== exp_a.zone_out) begin
                $display("%0t: zone_out exp %0d got %0d", $realtime, exp_a.zone_out,
                         got.zone_out);
                errors++;
            end
            if (got.present !== exp_a.present) begin
                $display("%0t: present exp %0d got %0d zone %0d", $realtime,
                         exp_a.present, got.present, exp_a.zone_out);
                errors++;
            end
            if (got.stat_value !== exp_a.stat_value) begin
                $display("%0t: stat_value exp %h got %h zone %0d", $realtime,
                         exp_a.stat_value, got.stat_value, exp_a.zone_out);
                errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [79:0] m_tdata;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    zone_stats_board board;
    int send_idle_pct, recv_idle_pct;
    int items_sent;

    zonal_statistics_accumulator_top uut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // hard ceiling well above the slowest legal run
    initial begin
        #50ms;
        $display("zonal_statistics_accumulator_top_tb NOT OK");
        $finish;
    end

    // receiver side: random backpressure, check at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_answer(m_tdata[72:0]);
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // register write: setup cycle then access cycle
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        board.write_reg(idx, val);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // one input transfer, sender gaps drawn before it
    task automatic send_item(logic [1:0] op, logic [7:0] zone, logic [31:0] sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1; s_tuser <= op; s_tdata <= {sample, zone};
        do @(posedge aclk); while (!s_tready);
        board.note_input(op, zone, sample);
        items_sent++;
        @(negedge aclk);
    endtask

    // wait until every answer is in, then let clears and skipped pixels drain
    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // well-formed bursts: pixels and queries on four adjacent zones, then a query
    task automatic random_phase(int n);
        logic [7:0] base, z;
        int k;
        k = 0;
        while (k < n) begin
            base = 8'($urandom);
            repeat ($urandom_range(12, 3)) begin
                z = 8'(base + $urandom_range(3));
                case ($urandom_range(19))
                    0:       send_item(OP_CLEAR, 8'($urandom), $urandom);
                    1:       send_item(OP_UNUSED, 8'($urandom), $urandom);   // ignored
                    2, 3, 4: send_item(OP_QUERY, z, $urandom);
                    5:       send_item(OP_ACC, board.zskip_code, rand_sample());
                    6:       send_item(OP_ACC, z, board.vskip_code);
                    default: send_item(OP_ACC, z, rand_sample());
                endcase
                k++;
            end
            send_item(OP_QUERY, 8'(base + $urandom_range(3)), $urandom);
            k++;
        end
    endtask

    initial begin
        logic [2:0] sel;
        board = new();
        board.reset_state();
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tuser = OP_ACC; m_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        send_idle_pct = 0; recv_idle_pct = 0; items_sent = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes, unused selector, skips and clear
        apb_write(REG_STAT_SELECT, 32'(STAT_SUM));
        send_item(OP_QUERY, 8'd0, 32'd0);                 // absent zone
        send_item(OP_ACC, 8'd255, 32'h7FFF_FFFF);
        send_item(OP_ACC, 8'd255, 32'h7FFF_FFFF);
        send_item(OP_ACC, 8'd0, 32'h8000_0000);
        send_item(OP_ACC, 8'd0, 32'hFFFF_FFFF);
        send_item(OP_ACC, 8'd0, 32'h0001_0000);
        send_item(OP_QUERY, 8'd255, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 8'd0, 32'd0);
        send_item(OP_QUERY, 8'hAA, 32'd0);
        send_item(OP_UNUSED, 8'd0, 32'd0);
        drain();
        for (int s = 0; s < 8; s++) begin
            apb_write(REG_STAT_SELECT, s);
            send_item(OP_QUERY, 8'd0, 32'd0);
            drain();
        end
        apb_write(REG_VSKIP_EN, 1);
        apb_write(REG_VSKIP_CODE, 32'h8000_0000);
        apb_write(REG_ZSKIP_EN, 1);
        apb_write(REG_ZSKIP_CODE, 32'd255);
        apb_write(REG_STAT_SELECT, 32'(STAT_COUNT));
        send_item(OP_ACC, 8'd255, 32'd5);                  // zone skipped
        send_item(OP_ACC, 8'd0, 32'h8000_0000);            // value skipped
        send_item(OP_QUERY, 8'd0, 32'd0);
        send_item(OP_CLEAR, 8'd0, 32'd0);
        send_item(OP_QUERY, 8'd0, 32'd0);
        drain();

        // random phases over the stat selections, with random skip settings
        for (int ph = 0; ph < 15; ph++) begin
            send_idle_pct = (ph < 5) ? 34 : (ph < 10) ? 73 : 0;
            recv_idle_pct = (ph < 5) ? 73 : (ph < 10) ? 34 : 0;
            if (ph == 14) recv_idle_pct = 0;
            sel = 3'(ph % 6);
            apb_write(REG_STAT_SELECT, (sel == 5) ? $urandom_range(7, 5) : 32'(sel));
            apb_write(REG_VSKIP_EN, $urandom_range(1));
            apb_write(REG_VSKIP_CODE, (ph % 3 == 0) ? 32'h7FFF_FFFF : $urandom_range(10) - 5);
            apb_write(REG_ZSKIP_EN, $urandom_range(1));
            apb_write(REG_ZSKIP_CODE, (ph % 2) ? 32'd0 : 32'($urandom_range(255)));
            random_phase(66);
            drain();
        end

        $display("sent %0d input transfers, checked %0d query answers over 15 phases",
                 items_sent, board.answers);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("zonal_statistics_accumulator_top_tb OK");
        else
            $display("zonal_statistics_accumulator_top_tb NOT OK");
        $finish;
    end
endmodule

>>> zonal_statistics_accumulator_top.f
hdl/zsa_pkg.sv
hdl/zsa_front.sv
hdl/zsa_div.sv
hdl/zsa_back.sv
hdl/zonal_statistics_accumulator_top.sv
tb/zonal_statistics_accumulator_top_tb.sv
